[design/sfd_pkg.sv]
package sfd_pkg;

   localparam int FRAME_BYTES = 25;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int FLAG_BYTE   = 23;
   localparam int LAST_DATA   = FLAG_BYTE - 1;
   localparam int NUM_ANALOG  = 16;
   localparam int CH_BITS     = 11;
   localparam int ACC_W       = CH_BITS + 7;
   localparam int CNT_W       = 5;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NIBBLE  = 2'd2;

   localparam logic [7:0] HEADER_RESET = 8'h0F;
   localparam logic [7:0] END_RESET    = 8'h00;
   localparam logic [3:0] NIBBLE_RESET = 4'h4;

   // circular add on window addresses, both operands below FRAME_BYTES
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] n);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, n};
      if (s >= (ADDR_W+1)'(FRAME_BYTES)) begin
         s = s - (ADDR_W+1)'(FRAME_BYTES);
      end
      return s[ADDR_W-1:0];
   endfunction

endpackage

[design/sfd_ram.sv]
module sfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[design/sbus_frame_decoder.sv]
// Channel | Direction | Transfer contents
// req     | in        | tdata[7:0] rx_byte
// rsp     | out       | tdata channel, value; tuser frame_lost, failsafe, lost_sync; tlast last
// csr     | in        | index 0 header_byte, 1 end_byte, 2 end_nibble (index 3 ignored)
//
// The next byte is taken in the cycle the previous byte's window check runs, so
// bytes that complete no frame stream at one per cycle unless a lost-sync result
// waits on a stalled rsp. A completed frame holds req through the window check,
// the flag read, one window RAM read per data byte (single read port) for the 22
// data bytes carrying channels 0..15, then the two digital results.
// Reset is synchronous; the window reads as zeros until written (valid bits).
// A stalled rsp holds the result register and halts decoding once a result is due.
module sbus_frame_decoder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] channel, [15:5] value
   output logic [2:0]  rsp_tuser,   // [0] frame_lost, [1] failsafe, [2] lost_sync
   output logic        rsp_tlast,   // last

   input  logic                             csr_wr_en,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                       csr_wdata
);

   typedef enum logic [1:0] {ST_RUN, ST_FLAG, ST_DATA} state_type;

   localparam int AW = sfd_pkg::ADDR_W;
   localparam int CW = sfd_pkg::CNT_W;

   state_type state_ff, state_in;
   logic                      chk_ff, chk_in;
   logic [7:0]                newest_ff, newest_in;
   logic [AW-1:0]             base_ff, base_in;
   logic [AW-1:0]             wp_ff, wp_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [sfd_pkg::FRAME_BYTES-1:0] valid_ff, valid_in;
   logic                      rd_ok_ff, rd_ok_in;
   logic                      pend_ff, pend_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [sfd_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [CW-1:0]             bits_ff, bits_in;
   logic [CW-1:0]             ch_ff, ch_in;
   logic [3:0]                flags_ff, flags_in;
   logic [7:0]                hdr_ff, endb_ff;
   logic [3:0]                nib_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_ch_ff, rsp_ch_in;
   logic [10:0] rsp_val_ff, rsp_val_in;
   logic        rsp_lost_ff, rsp_lost_in;
   logic        rsp_fs_ff, rsp_fs_in;
   logic        rsp_ls_ff, rsp_ls_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                      ram_we, ram_re;
   logic [AW-1:0]             ram_raddr;
   logic [7:0]                ram_rd_data;
   logic [7:0]                rd_byte;
   logic                      out_free, found, lost, accept, emit;
   logic [CW-1:0]             cnt_inc, bits_eff;
   logic [sfd_pkg::ACC_W-1:0] acc_eff;

   sfd_ram #(
      .WIDTH (8),
      .DEPTH (sfd_pkg::FRAME_BYTES)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

   assign rd_byte  = rd_ok_ff ? ram_rd_data : 8'd0;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_inc  = cnt_ff + CW'(1);
   assign found    = chk_ff && (rd_byte == hdr_ff) &&
                     ((newest_ff == endb_ff) || (newest_ff[3:0] == nib_ff));
   assign lost     = chk_ff && !found && (cnt_inc == CW'(sfd_pkg::FRAME_BYTES));

   assign req_tready = (state_ff == ST_RUN) &&
                       (!chk_ff || (!found && (!lost || out_free)));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      chk_in       = chk_ff;
      newest_in    = newest_ff;
      base_in      = base_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      rd_ok_in     = rd_ok_ff;
      pend_in      = pend_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      bits_in      = bits_ff;
      ch_in        = ch_ff;
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_lost_in  = rsp_lost_ff;
      rsp_fs_in    = rsp_fs_ff;
      rsp_ls_in    = rsp_ls_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = base_ff;
      acc_eff      = acc_ff;
      bits_eff     = bits_ff;
      emit         = 1'b0;

      unique case (state_ff)
         ST_RUN: begin
            if (chk_ff) begin
               if (found) begin
                  cnt_in    = '0;
                  ram_re    = 1'b1;
                  ram_raddr = sfd_pkg::wrap_add(base_ff, AW'(sfd_pkg::FLAG_BYTE));
                  chk_in    = 1'b0;
                  state_in  = ST_FLAG;
               end else if (lost) begin
                  if (out_free) begin
                     cnt_in       = '0;
                     chk_in       = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_ch_in    = '0;
                     rsp_val_in   = '0;
                     rsp_lost_in  = 1'b1;
                     rsp_fs_in    = 1'b0;
                     rsp_ls_in    = 1'b1;
                     rsp_last_in  = 1'b1;
                  end
               end else begin
                  cnt_in = cnt_inc;
                  chk_in = 1'b0;
               end
            end
            if (accept) begin
               ram_we          = 1'b1;
               valid_in[wp_ff] = 1'b1;
               wp_in           = sfd_pkg::wrap_add(wp_ff, AW'(1));
               base_in         = sfd_pkg::wrap_add(wp_ff, AW'(1));
               newest_in       = req_tdata;
               ram_re          = 1'b1;
               ram_raddr       = sfd_pkg::wrap_add(wp_ff, AW'(1));
               chk_in          = 1'b1;
            end
         end
         ST_FLAG: begin
            flags_in  = rd_byte[3:0];
            ram_re    = 1'b1;
            ram_raddr = sfd_pkg::wrap_add(base_ff, AW'(1));
            idx_in    = CW'(2);
            pend_in   = 1'b1;
            acc_in    = '0;
            bits_in   = '0;
            ch_in     = '0;
            state_in  = ST_DATA;
         end
         ST_DATA: begin
            if (ch_ff < CW'(sfd_pkg::NUM_ANALOG)) begin
               if (pend_ff) begin
                  acc_eff  = acc_ff | (sfd_pkg::ACC_W'(rd_byte) << bits_ff);
                  bits_eff = bits_ff + CW'(8);
               end
               emit = (bits_eff >= CW'(sfd_pkg::CH_BITS)) && out_free;
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_ch_in    = ch_ff;
                  rsp_val_in   = acc_eff[10:0];
                  rsp_lost_in  = flags_ff[2];
                  rsp_fs_in    = flags_ff[3];
                  rsp_ls_in    = 1'b0;
                  rsp_last_in  = 1'b0;
                  acc_in       = acc_eff >> sfd_pkg::CH_BITS;
                  bits_in      = bits_eff - CW'(sfd_pkg::CH_BITS);
                  ch_in        = ch_ff + CW'(1);
               end else begin
                  acc_in  = acc_eff;
                  bits_in = bits_eff;
               end
               pend_in = 1'b0;
               if ((bits_in < CW'(sfd_pkg::CH_BITS)) &&
                   (idx_ff <= CW'(sfd_pkg::LAST_DATA))) begin
                  ram_re    = 1'b1;
                  ram_raddr = sfd_pkg::wrap_add(base_ff, idx_ff);
                  idx_in    = idx_ff + CW'(1);
                  pend_in   = 1'b1;
               end
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_lost_in  = flags_ff[2];
               rsp_fs_in    = flags_ff[3];
               rsp_ls_in    = 1'b0;
               if (ch_ff == CW'(sfd_pkg::NUM_ANALOG)) begin
                  rsp_val_in  = {10'd0, flags_ff[0]};
                  rsp_last_in = 1'b0;
                  ch_in       = ch_ff + CW'(1);
               end else begin
                  rsp_val_in  = {10'd0, flags_ff[1]};
                  rsp_last_in = 1'b1;
                  state_in    = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      if (ram_re) begin
         rd_ok_in = valid_ff[ram_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         chk_ff       <= 1'b0;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hdr_ff       <= sfd_pkg::HEADER_RESET;
         endb_ff      <= sfd_pkg::END_RESET;
         nib_ff       <= sfd_pkg::NIBBLE_RESET;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               sfd_pkg::CSR_HEADER: hdr_ff  <= csr_wdata;
               sfd_pkg::CSR_END:    endb_ff <= csr_wdata;
               sfd_pkg::CSR_NIBBLE: nib_ff  <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
      newest_in_reg: begin
         newest_ff   <= newest_in;
         base_ff     <= base_in;
         rd_ok_ff    <= rd_ok_in;
         idx_ff      <= idx_in;
         acc_ff      <= acc_in;
         bits_ff     <= bits_in;
         ch_ff       <= ch_in;
         flags_ff    <= flags_in;
         rsp_ch_ff   <= rsp_ch_in;
         rsp_val_ff  <= rsp_val_in;
         rsp_lost_ff <= rsp_lost_in;
         rsp_fs_ff   <= rsp_fs_in;
         rsp_ls_ff   <= rsp_ls_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_val_ff, rsp_ch_ff};
   assign rsp_tuser  = {rsp_ls_ff, rsp_fs_ff, rsp_lost_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
